### sv/bnll_loss_gradient_unit_macros.svh
// Assertion macros used by the RTL file of the loss and gradient unit.
`ifndef BNLL_LOSS_GRADIENT_UNIT_MACROS_SVH
`define BNLL_LOSS_GRADIENT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define BNLL_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define BNLL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define BNLL_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define BNLL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### sv/bnll_pkg.sv
package bnll_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IQ        = 30;
  localparam int DW        = 24;
  localparam int CLAMP_W   = 23;
  localparam logic [CLAMP_W-1:0] CLAMP_RST = CLAMP_W'(100 << FRAC_BITS);

  localparam int PROD_W = 2 * DW;
  localparam int Z_W    = PROD_W - FRAC_BITS;
  localparam int A_W    = FRAC_BITS + 5;
  localparam int SH_A   = IQ - FRAC_BITS;
  localparam int A30_W  = IQ + 5;
  localparam int RND_L  = (SH_A > 0) ? (1 << (SH_A - 1)) : 0;

  localparam logic [IQ-1:0] LN2_Q30 = IQ'(744261118);
  localparam int K_SH = SH_A + 32;
  localparam logic [63:0] K_RECIP = (64'd1 << K_SH) / 64'(LN2_Q30);
  localparam int KR_W = $clog2(K_RECIP + 1);
  localparam int K_W  = 6;

  localparam int TAY_N  = 16;
  localparam int LOG_N  = 14;
  localparam int DIV_N  = IQ + 1;
  localparam int ACC_W  = IQ + 3;
  localparam int Q_W    = IQ + 1;
  localparam int D_W    = IQ + 2;
  localparam int SUM_W  = IQ + 1;
  localparam int LQ_W   = SUM_W + 1;
  localparam int GM_W   = DW + Q_W;
  localparam int GA_W   = GM_W + 1 - IQ;

  // Stage positions along the valid shift line.
  localparam int ST_TAY  = 6;
  localparam int ST_EXP  = ST_TAY + 2 * TAY_N;
  localparam int ST_DIV  = ST_EXP + 1;
  localparam int ST_POST = ST_DIV + DIV_N;
  localparam int ST_LOG  = ST_POST + 1;
  localparam int ST_FIN  = ST_LOG + LOG_N + 1;
  localparam int N_STG   = ST_FIN + 2;

  typedef struct packed {
    logic signed [DW-1:0]  y;
    logic signed [Z_W-1:0] z;
    logic                  last;
  } side_t;

endpackage

### sv/bnll_loss_gradient_unit.sv
// Softplus loss and gradient unit, one element per item.
// Input channel: label_i and score_i (signed Q8.16) and last_in_i, under
// in_valid_i / in_ready_o. Output channel: loss_o (unsigned Q8.16),
// gradient_o (signed Q8.16) and last_out_o, under out_valid_o / out_ready_i.
// cfg_we_i writes cfg_margin_clamp_i into the margin clamp register; write it
// only while no item is in flight.
// The datapath holds the exponent series up to the 16th power of r, the 31-step
// restoring divider and the 14-term log series, each step a pipeline stage.
// Throughput is one item per cycle while the output is not stalled.
// Reset clears all valid bits and the skid stage and sets the margin clamp
// to 100.0.
// When the receiver stalls, the last pipeline result moves into a skid stage
// and the whole pipeline then holds with in_ready_o low until the skid stage
// drains, so no item is lost or repeated.
`include "bnll_loss_gradient_unit_macros.svh"

module bnll_loss_gradient_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bnll_pkg::CLAMP_W-1:0]      cfg_margin_clamp_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [bnll_pkg::DW-1:0]    label_i,
  input  logic signed [bnll_pkg::DW-1:0]    score_i,
  input  logic                              last_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bnll_pkg::DW-1:0]           loss_o,
  output logic signed [bnll_pkg::DW-1:0]    gradient_o,
  output logic                              last_out_o
);
  import bnll_pkg::*;

  logic [CLAMP_W-1:0] clamp_q;
  logic [N_STG-1:0]   vld_q;
  logic               skid_q;
  logic               adv;

  assign adv        = !skid_q;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_q <= CLAMP_RST;
    end else if (cfg_we_i) begin
      clamp_q <= cfg_margin_clamp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[N_STG-2:0], in_valid_i};
    end
  end

  // Front: product, margin, clamp and range reduction.
  logic signed [DW-1:0]     y0_q, f0_q, y1_q;
  logic                     last0_q, last1_q;
  logic signed [PROD_W-1:0] prod1_q;
  side_t                    side2_q, side3_q, side4_q, side5_q;
  logic [A_W-1:0]           a2_q, a3_q;
  logic                     big2_q, big3_q, big4_q, big5_q;
  logic [A_W+KR_W-1:0]      kmul3_q;
  logic [K_W-1:0]           k4_q, k5_q;
  logic [IQ:0]              r4_q;
  logic [IQ-1:0]            r5_q;

  logic                     pneg;
  logic [PROD_W-1:0]        pmag;
  logic [PROD_W:0]          qsum;
  logic signed [Z_W:0]      z_raw;
  logic signed [Z_W-1:0]    z_c;
  logic [Z_W-1:0]           a_c;
  logic [K_W-1:0]           k0;
  logic [A30_W-1:0]         a30, r0;
  logic                     rge;

  always_comb begin
    pneg  = prod1_q[PROD_W-1];
    pmag  = pneg ? PROD_W'(-prod1_q) : PROD_W'(prod1_q);
    qsum  = ((PROD_W+1)'(pmag) + (PROD_W+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    z_raw = pneg ? ((Z_W+1)'(1 << FRAC_BITS) + $signed((Z_W+1)'(qsum)))
                 : ((Z_W+1)'(1 << FRAC_BITS) - $signed((Z_W+1)'(qsum)));
    if (z_raw > $signed((Z_W+1)'(clamp_q))) begin
      z_c = $signed(Z_W'(clamp_q));
    end else begin
      z_c = Z_W'(z_raw);
    end
    a_c = z_c[Z_W-1] ? Z_W'(-z_c) : Z_W'(z_c);
    k0  = K_W'(kmul3_q >> 32);
    a30 = {a3_q, {SH_A{1'b0}}};
    r0  = a30 - A30_W'(k0) * A30_W'(LN2_Q30);
    rge = r4_q >= (IQ+1)'(LN2_Q30);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y0_q        <= label_i;
      f0_q        <= score_i;
      last0_q     <= last_in_i;
      prod1_q     <= y0_q * f0_q;
      y1_q        <= y0_q;
      last1_q     <= last0_q;
      side2_q     <= '{y: y1_q, z: z_c, last: last1_q};
      a2_q        <= a_c[A_W-1:0];
      big2_q      <= |a_c[Z_W-1:A_W];
      side3_q     <= side2_q;
      a3_q        <= a2_q;
      big3_q      <= big2_q;
      kmul3_q     <= a2_q * K_RECIP[KR_W-1:0];
      side4_q     <= side3_q;
      big4_q      <= big3_q;
      k4_q        <= k0;
      r4_q        <= r0[IQ:0];
      side5_q     <= side4_q;
      big5_q      <= big4_q;
      k5_q        <= k4_q + K_W'(rge);
      r5_q        <= rge ? IQ'(r4_q - (IQ+1)'(LN2_Q30)) : IQ'(r4_q);
    end
  end

  // Exponent series: two stages per term, multiply by r then divide by j.
  logic [IQ-1:0]           t_val_q  [2*TAY_N];
  logic signed [ACC_W-1:0] t_acc_q  [2*TAY_N];
  logic [K_W-1:0]          t_k_q    [2*TAY_N];
  logic [IQ-1:0]           t_r_q    [2*TAY_N];
  logic                    t_big_q  [2*TAY_N];
  side_t                   t_side_q [2*TAY_N];

  for (genvar m = 0; m < 2 * TAY_N; m++) begin : g_tay
    logic [K_W-1:0] k_in;
    logic [IQ-1:0]  r_in;
    logic           big_in;
    side_t          side_in;
    if (m == 0) begin : g_src0
      assign k_in    = k5_q;
      assign r_in    = r5_q;
      assign big_in  = big5_q;
      assign side_in = side5_q;
    end else begin : g_srcn
      assign k_in    = t_k_q[m-1];
      assign r_in    = t_r_q[m-1];
      assign big_in  = t_big_q[m-1];
      assign side_in = t_side_q[m-1];
    end

    if (m % 2 == 0) begin : g_mul
      logic [IQ:0]             term_in;
      logic signed [ACC_W-1:0] acc_in, tsg, acc_out;
      logic [2*IQ:0]           tr;
      if (m == 0) begin : g_first
        assign term_in = (IQ+1)'(1) << IQ;
        assign acc_in  = '0;
      end else begin : g_next
        assign term_in = (IQ+1)'(t_val_q[m-1]);
        assign acc_in  = t_acc_q[m-1];
      end
      assign tsg     = $signed(ACC_W'(term_in));
      assign acc_out = ((m / 2) % 2 == 1) ? (acc_in - tsg) : (acc_in + tsg);
      assign tr      = term_in * r_in;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          t_val_q[m] <= IQ'(tr >> IQ);
          t_acc_q[m] <= acc_out;
        end
      end
    end else begin : g_div
      localparam int          DIV = m / 2 + 1;
      localparam int          LG  = $clog2(DIV);
      localparam logic [63:0] MR  = ((64'd1 << (IQ + LG)) + 64'(DIV) - 64'd1) / 64'(DIV);
      logic [IQ+32-1:0] xm;
      assign xm = t_val_q[m-1] * MR[31:0];
      always_ff @(posedge clk_i) begin
        if (adv) begin
          t_val_q[m] <= IQ'(xm >> (IQ + LG));
          t_acc_q[m] <= t_acc_q[m-1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        t_k_q[m]    <= k_in;
        t_r_q[m]    <= r_in;
        t_big_q[m]  <= big_in;
        t_side_q[m] <= side_in;
      end
    end
  end

  // Exponent result, then the divisor 1 + e.
  logic signed [ACC_W-1:0] accf;
  logic [ACC_W-1:0]        accp;
  logic [Q_W-1:0]          e_c;
  logic [D_W-1:0]          e_d_q;
  side_t                   e_side_q;

  always_comb begin
    accf = t_acc_q[2*TAY_N-1] + $signed(ACC_W'(t_val_q[2*TAY_N-1]));
    accp = accf[ACC_W-1] ? '0 : ACC_W'(accf);
    e_c  = t_big_q[2*TAY_N-1] ? '0 : Q_W'(accp >> t_k_q[2*TAY_N-1]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_d_q    <= (D_W'(1) << IQ) + D_W'(e_c);
      e_side_q <= t_side_q[2*TAY_N-1];
    end
  end

  // Restoring divider of 2^(2*IQ) by 1 + e, one quotient bit per stage.
  logic [D_W-1:0] dv_rem_q  [DIV_N];
  logic [Q_W-1:0] dv_quo_q  [DIV_N];
  logic [D_W-1:0] dv_d_q    [DIV_N];
  side_t          dv_side_q [DIV_N];

  for (genvar t = 0; t < DIV_N; t++) begin : g_div
    logic [D_W-1:0] rem_in, d_in;
    logic [Q_W-1:0] quo_in;
    side_t          side_in;
    logic [D_W:0]   rem2;
    logic           ge;
    if (t == 0) begin : g_src0
      assign rem_in  = D_W'(1) << (IQ - 1);
      assign quo_in  = '0;
      assign d_in    = e_d_q;
      assign side_in = e_side_q;
    end else begin : g_srcn
      assign rem_in  = dv_rem_q[t-1];
      assign quo_in  = dv_quo_q[t-1];
      assign d_in    = dv_d_q[t-1];
      assign side_in = dv_side_q[t-1];
    end
    assign rem2 = {rem_in, 1'b0};
    assign ge   = rem2 >= (D_W+1)'(d_in);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[t]  <= ge ? D_W'(rem2 - (D_W+1)'(d_in)) : D_W'(rem2);
        dv_quo_q[t]  <= {quo_in[Q_W-2:0], ge};
        dv_d_q[t]    <= d_in;
        dv_side_q[t] <= side_in;
      end
    end
  end

  // Sigmoid and the log series argument s = e / (1 + e).
  logic [Q_W-1:0] ps_s;
  logic [IQ-1:0]  po_s_q;
  logic [Q_W-1:0] po_sig_q;
  side_t          po_side_q;

  assign ps_s = (Q_W'(1) << IQ) - dv_quo_q[DIV_N-1] - Q_W'(|dv_rem_q[DIV_N-1]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      po_s_q    <= IQ'(ps_s);
      po_sig_q  <= dv_side_q[DIV_N-1].z[Z_W-1] ? ps_s : dv_quo_q[DIV_N-1];
      po_side_q <= dv_side_q[DIV_N-1];
    end
  end

  // Log series: stage 0 squares s, stage i+1 adds term i-1 and forms term i.
  logic [IQ-1:0]    l_p_q    [LOG_N+1];
  logic [IQ-1:0]    l_s2_q   [LOG_N+1];
  logic [SUM_W-1:0] l_sum_q  [LOG_N+1];
  logic [IQ-1:0]    l_qd_q   [LOG_N+1];
  logic [Q_W-1:0]   l_sig_q  [LOG_N+1];
  side_t            l_side_q [LOG_N+1];

  logic [2*IQ-1:0] sq;
  assign sq = po_s_q * po_s_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l_p_q[0]    <= po_s_q;
      l_s2_q[0]   <= IQ'(sq >> IQ);
      l_sum_q[0]  <= '0;
      l_qd_q[0]   <= '0;
      l_sig_q[0]  <= po_sig_q;
      l_side_q[0] <= po_side_q;
    end
  end

  for (genvar i = 0; i < LOG_N; i++) begin : g_log
    localparam int          DIV = 2 * i + 1;
    localparam int          LG  = $clog2(DIV);
    localparam logic [63:0] MR  = ((64'd1 << (IQ + LG)) + 64'(DIV) - 64'd1) / 64'(DIV);
    logic [IQ+32-1:0] pm;
    logic [2*IQ-1:0]  ps;
    assign pm = l_p_q[i] * MR[31:0];
    assign ps = l_p_q[i] * l_s2_q[i];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        l_sum_q[i+1]  <= l_sum_q[i] + SUM_W'(l_qd_q[i]);
        l_qd_q[i+1]   <= IQ'(pm >> (IQ + LG));
        l_p_q[i+1]    <= IQ'(ps >> IQ);
        l_s2_q[i+1]   <= l_s2_q[i];
        l_sig_q[i+1]  <= l_sig_q[i];
        l_side_q[i+1] <= l_side_q[i];
      end
    end
  end

  // Final stages: log sum and gradient product, then rounding and saturation.
  logic [SUM_W-1:0] sumf;
  logic [DW-1:0]    yabs;
  logic [LQ_W-1:0]  f_lossq_q;
  logic [GM_W-1:0]  f_gmag_q;
  side_t            f_side_q;

  assign sumf = l_sum_q[LOG_N] + SUM_W'(l_qd_q[LOG_N]);
  assign yabs = l_side_q[LOG_N].y[DW-1] ? DW'(-l_side_q[LOG_N].y) : DW'(l_side_q[LOG_N].y);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_lossq_q <= {sumf, 1'b0};
      f_gmag_q  <= yabs * l_sig_q[LOG_N];
      f_side_q  <= l_side_q[LOG_N];
    end
  end

  logic [LQ_W:0]        lsum;
  logic [GA_W-1:0]      gabs;
  logic [DW-1:0]        loss_c;
  logic signed [DW-1:0] grad_c;

  always_comb begin
    lsum = ((LQ_W+1)'(f_lossq_q) + (LQ_W+1)'(RND_L)) >> SH_A;
    if (!f_side_q.z[Z_W-1] && (f_side_q.z != '0)) begin
      lsum = lsum + (LQ_W+1)'(f_side_q.z);
    end
    loss_c = (lsum > (LQ_W+1)'({DW{1'b1}})) ? {DW{1'b1}} : DW'(lsum);
    gabs   = GA_W'((GM_W+1)'(f_gmag_q) + ((GM_W+1)'(1) << (IQ - 1)) >> IQ);
    if (!f_side_q.y[DW-1] && (f_side_q.y != '0)) begin
      if (gabs > (GA_W'(1) << (DW - 1))) begin
        gabs = GA_W'(1) << (DW - 1);
      end
      grad_c = DW'(-gabs);
    end else begin
      if (gabs > GA_W'({(DW-1){1'b1}})) begin
        gabs = GA_W'({(DW-1){1'b1}});
      end
      grad_c = DW'(gabs);
    end
  end

  logic [DW-1:0]        o_loss_q, sk_loss_q;
  logic signed [DW-1:0] o_grad_q, sk_grad_q;
  logic                 o_last_q, sk_last_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_loss_q <= loss_c;
      o_grad_q <= grad_c;
      o_last_q <= f_side_q.last;
    end
  end

  // Skid stage: catches the result that the pipeline pushes out during a stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_q <= 1'b0;
    end else if (skid_q) begin
      if (out_ready_i) begin
        skid_q <= 1'b0;
      end
    end else if (vld_q[N_STG-1] && !out_ready_i) begin
      skid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_q) begin
      sk_loss_q <= o_loss_q;
      sk_grad_q <= o_grad_q;
      sk_last_q <= o_last_q;
    end
  end

  assign out_valid_o = skid_q || vld_q[N_STG-1];
  assign loss_o      = skid_q ? sk_loss_q : o_loss_q;
  assign gradient_o  = skid_q ? sk_grad_q : o_grad_q;
  assign last_out_o  = skid_q ? sk_last_q : o_last_q;

  `BNLL_ASSERT_NEXT(a_skid_load, clk_i, rst_ni, vld_q[N_STG-1] && !out_ready_i && !skid_q, skid_q && out_valid_o, "Stalled item was not kept in the skid stage.")
  `BNLL_ASSERT_IMPL(a_ready_stall, clk_i, rst_ni, !in_ready_o, out_valid_o && skid_q, "Input stalled without a waiting item.")

endmodule
